// File: hdl/ard_se_kernel_covariance_core_defines.svh
// assertion macros for the covariance kernel core
`ifndef ARD_SE_KERNEL_COVARIANCE_CORE_DEFINES_SVH
`define ARD_SE_KERNEL_COVARIANCE_CORE_DEFINES_SVH

`ifndef SYNTH
`define KCOV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KCOV_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCOV_ASSERT(label, prop, msg)
`define KCOV_ASSERT_NR(label, prop, msg)
`endif

`endif

// File: hdl/kcov_pkg.sv
package kcov_pkg;

  localparam int EXP_TERMS = 10;
  localparam int RECIP_SHIFT = 36;
  localparam logic [31:0] HALF_LOG2E = 32'd3098164010;
  localparam logic [31:0] LN2 = 32'd2977044472;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_NOISE    = 2'd0,
    CFG_VARIANCE = 2'd1,
    CFG_INV_X    = 2'd2,
    CFG_INV_Y    = 2'd3
  } kcov_cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
  } kcov_in_t;

  typedef struct packed {
    logic [31:0] covariance_value;
    logic [31:0] grad_noise;
    logic [32:0] grad_variance;
    logic [31:0] grad_scale_x;
    logic [31:0] grad_scale_y;
    logic        positions_equal;
  } kcov_out_t;

  // travels alongside the exp pipeline
  typedef struct packed {
    logic        eq;
    logic [47:0] zx;
    logic [47:0] zy;
  } kcov_tag_t;

endpackage

// File: hdl/kcov_dist.sv
module kcov_dist
  import kcov_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_vld,
  input  kcov_in_t    in_data,
  input  logic [23:0] inv_x,
  input  logic [23:0] inv_y,
  output logic        t_vld,
  output logic [31:0] t_val,
  output kcov_tag_t   t_tag
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        eq1_r, eq2_r, eq3_r;
  logic [31:0] dx_r, dy_r;
  logic [31:0] sx_r, sy_r;
  logic [47:0] zx_r, zy_r;
  logic [31:0] t_r;
  kcov_tag_t   tag_r;

  logic signed [32:0] diff_x, diff_y;
  logic [32:0]        adx, ady;
  logic [55:0]        px, py;
  logic [63:0]        qx, qy;
  logic [48:0]        zsum;
  logic [31:0]        sx_nxt, sy_nxt, t_nxt;

  always_comb begin
    diff_x = {in_data.first_x[31], in_data.first_x} - {in_data.second_x[31], in_data.second_x};
    diff_y = {in_data.first_y[31], in_data.first_y} - {in_data.second_y[31], in_data.second_y};
    adx    = diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
    ady    = diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
    px     = 56'(dx_r) * 56'(inv_x);
    py     = 56'(dy_r) * 56'(inv_y);
    sx_nxt = (px[55:48] != 8'd0) ? MAX32 : px[47:16];
    sy_nxt = (py[55:48] != 8'd0) ? MAX32 : py[47:16];
    qx     = 64'(sx_r) * 64'(sx_r);
    qy     = 64'(sy_r) * 64'(sy_r);
    zsum   = 49'(zx_r) + 49'(zy_r);
    t_nxt  = (zsum[48:32] != 17'd0) ? MAX32 : zsum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r      <= adx[31:0];
      dy_r      <= ady[31:0];
      eq1_r     <= (in_data.first_x == in_data.second_x) &&
                   (in_data.first_y == in_data.second_y);
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
      eq2_r     <= eq1_r;
      zx_r      <= qx[63:16];
      zy_r      <= qy[63:16];
      eq3_r     <= eq2_r;
      t_r       <= t_nxt;
      tag_r.eq  <= eq3_r;
      tag_r.zx  <= zx_r;
      tag_r.zy  <= zy_r;
    end
  end

  assign t_vld = v4_r;
  assign t_val = t_r;
  assign t_tag = tag_r;

endmodule

// File: hdl/kcov_exp.sv
module kcov_exp
  import kcov_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        t_vld,
  input  logic [31:0] t_val,
  input  kcov_tag_t   t_tag,
  output logic        e_vld,
  output logic [32:0] e_val,
  output kcov_tag_t   e_tag
);

  typedef struct packed {
    logic [31:0] x;
    logic [4:0]  n;
    logic        zf;
    kcov_tag_t   tag;
  } kcov_hside_t;

  logic        ua_vld_r;
  logic [31:0] ua_r;
  kcov_tag_t   ua_tag_r;
  logic        xb_vld_r;
  kcov_hside_t xb_side_r;
  logic        e_vld_r;
  logic [32:0] e_r;
  kcov_tag_t   e_tag_r;

  logic [63:0] u_prod;
  logic [47:0] x_prod;

  logic [32:0] p_w    [EXP_TERMS+1];
  kcov_hside_t side_w [EXP_TERMS+1];
  logic        vld_w  [EXP_TERMS+1];

  assign u_prod = 64'(t_val) * 64'(HALF_LOG2E);
  assign x_prod = 48'(ua_r[15:0]) * 48'(LN2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ua_vld_r <= 1'b0;
      xb_vld_r <= 1'b0;
      e_vld_r  <= 1'b0;
    end else if (adv) begin
      ua_vld_r <= t_vld;
      xb_vld_r <= ua_vld_r;
      e_vld_r  <= vld_w[EXP_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ua_r          <= u_prod[63:32];
      ua_tag_r      <= t_tag;
      xb_side_r.x   <= x_prod[47:16];
      xb_side_r.n   <= ua_r[20:16];
      // shift of 32 or more leaves nothing
      xb_side_r.zf  <= (ua_r[31:21] != 11'd0);
      xb_side_r.tag <= ua_tag_r;
      e_r           <= side_w[EXP_TERMS].zf ? 33'd0 : (p_w[EXP_TERMS] >> side_w[EXP_TERMS].n);
      e_tag_r       <= side_w[EXP_TERMS].tag;
    end
  end

  assign p_w[0]    = ONE_Q32;
  assign side_w[0] = xb_side_r;
  assign vld_w[0]  = xb_vld_r;

  // horner step j: p = 1 - floor((x*p >> 32) / j), three stages each
  for (genvar g = 0; g < EXP_TERMS; g++) begin : g_horner
    localparam int J = EXP_TERMS - g;
    localparam logic [36:0] RECIP = 37'((64'd1 << RECIP_SHIFT) / J);

    logic        a_vld_r, b_vld_r, c_vld_r;
    logic [31:0] a_q_r, b_q_r, b_appr_r;
    kcov_hside_t a_side_r, b_side_r, c_side_r;
    logic [32:0] c_p_r;

    logic [64:0] xp;
    logic [68:0] mq;
    logic [35:0] aj, rem;
    logic [31:0] quo;

    always_comb begin
      xp  = 65'(side_w[g].x) * 65'(p_w[g]);
      mq  = 69'(a_q_r) * 69'(RECIP);
      aj  = 36'(b_appr_r) * 36'(J);
      rem = 36'(b_q_r) - aj;
      // reciprocal estimate is at most one low
      quo = b_appr_r + 32'(rem >= 36'(J));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r <= 1'b0;
        b_vld_r <= 1'b0;
        c_vld_r <= 1'b0;
      end else if (adv) begin
        a_vld_r <= vld_w[g];
        b_vld_r <= a_vld_r;
        c_vld_r <= b_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_q_r    <= xp[63:32];
        a_side_r <= side_w[g];
        b_appr_r <= mq[67:36];
        b_q_r    <= a_q_r;
        b_side_r <= a_side_r;
        c_p_r    <= ONE_Q32 - 33'(quo);
        c_side_r <= b_side_r;
      end
    end

    assign p_w[g+1]    = c_p_r;
    assign side_w[g+1] = c_side_r;
    assign vld_w[g+1]  = c_vld_r;
  end

  assign e_vld = e_vld_r;
  assign e_val = e_r;
  assign e_tag = e_tag_r;

endmodule

// File: hdl/kcov_out.sv
module kcov_out
  import kcov_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        e_vld,
  input  logic [32:0] e_val,
  input  kcov_tag_t   e_tag,
  input  logic [31:0] variance,
  input  logic [31:0] noise,
  output logic        o_vld,
  output kcov_out_t   o_data
);

  logic        k_vld_r, g_vld_r, f_vld_r;
  logic [31:0] k_r, gk_r;
  kcov_tag_t   k_tag_r;
  logic        g_eq_r;
  logic [55:0] xl_r, xh_r, yl_r, yh_r;
  kcov_out_t   f_r;

  logic [64:0] kprod;
  logic [79:0] fx, fy;
  logic [31:0] nz;
  logic [32:0] cov;

  always_comb begin
    kprod = 65'(variance) * 65'(e_val);
    fx    = {xh_r, 24'd0} + 80'(xl_r);
    fy    = {yh_r, 24'd0} + 80'(yl_r);
    nz    = g_eq_r ? noise : 32'd0;
    cov   = 33'(gk_r) + 33'(nz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (adv) begin
      k_vld_r <= e_vld;
      g_vld_r <= k_vld_r;
      f_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r                <= kprod[63:32];
      k_tag_r            <= e_tag;
      // 48x32 products split in two 24-bit halves
      xl_r               <= 56'(k_tag_r.zx[23:0]) * 56'(k_r);
      xh_r               <= 56'(k_tag_r.zx[47:24]) * 56'(k_r);
      yl_r               <= 56'(k_tag_r.zy[23:0]) * 56'(k_r);
      yh_r               <= 56'(k_tag_r.zy[47:24]) * 56'(k_r);
      gk_r               <= k_r;
      g_eq_r             <= k_tag_r.eq;
      f_r.covariance_value <= cov[32] ? MAX32 : cov[31:0];
      f_r.grad_noise     <= nz;
      f_r.grad_variance  <= {gk_r, 1'b0};
      f_r.grad_scale_x   <= (fx[79:48] != 32'd0) ? MAX32 : fx[47:16];
      f_r.grad_scale_y   <= (fy[79:48] != 32'd0) ? MAX32 : fy[47:16];
      f_r.positions_equal <= g_eq_r;
    end
  end

  assign o_vld  = f_vld_r;
  assign o_data = f_r;

endmodule

// File: hdl/ard_se_kernel_covariance_core.sv
// channel   dir  handshake              payload
// in_       in   in_valid / in_ready    kcov_in_t, two 2-D positions
// out_      out  out_valid / out_ready  kcov_out_t, covariance and gradient
// cfg_      in   cfg_we                 cfg_index, cfg_wdata
//
// one beat per cycle in and out unless the output stalls; the pipeline is the
// ten-step exp polynomial (three stages per step) plus distance and output stages
// synchronous active-low reset clears valid bits and loads register defaults
// a held result at the output stalls the whole pipeline; nothing is dropped
`include "ard_se_kernel_covariance_core_defines.svh"

module ard_se_kernel_covariance_core
  import kcov_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  kcov_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output kcov_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] noise_r, variance_r;
  logic [23:0] inv_x_r, inv_y_r;

  logic        adv;
  logic        t_vld, e_vld;
  logic [31:0] t_val;
  logic [32:0] e_val;
  kcov_tag_t   t_tag, e_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r    <= 32'd0;
      variance_r <= 32'd65536;
      inv_x_r    <= 24'd65536;
      inv_y_r    <= 24'd65536;
    end else if (cfg_we) begin
      case (kcov_cfg_idx_t'(cfg_index))
        CFG_NOISE:    noise_r    <= cfg_wdata;
        CFG_VARIANCE: variance_r <= cfg_wdata;
        CFG_INV_X:    inv_x_r    <= cfg_wdata[23:0];
        CFG_INV_Y:    inv_y_r    <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output beat is stuck
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  kcov_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .in_data (in_data),
    .inv_x   (inv_x_r),
    .inv_y   (inv_y_r),
    .t_vld   (t_vld),
    .t_val   (t_val),
    .t_tag   (t_tag)
  );

  kcov_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .t_vld (t_vld),
    .t_val (t_val),
    .t_tag (t_tag),
    .e_vld (e_vld),
    .e_val (e_val),
    .e_tag (e_tag)
  );

  kcov_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .e_vld    (e_vld),
    .e_val    (e_val),
    .e_tag    (e_tag),
    .variance (variance_r),
    .noise    (noise_r),
    .o_vld    (out_valid),
    .o_data   (out_data)
  );

  `KCOV_ASSERT(a_noise_only_equal, out_valid && !out_data.positions_equal |-> out_data.grad_noise == 32'd0, "noise gradient on distinct positions")
  `KCOV_ASSERT(a_cov_ge_kernel, out_valid |-> out_data.covariance_value >= out_data.grad_variance[32:1], "covariance below kernel value")
  `KCOV_ASSERT(a_gv_even, out_valid |-> !out_data.grad_variance[0], "variance gradient odd")
  `KCOV_ASSERT_NR(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule
